@@ src/tick_phase_lock_calibrator_assert.svh @@
// Assertion macros for the tick phase lock calibrator checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef TICK_PHASE_LOCK_CALIBRATOR_ASSERT_SVH
`define TICK_PHASE_LOCK_CALIBRATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define TPLC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define TPLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/tplc_pkg.sv @@
// Package for the tick phase lock calibrator: widths, codes, reset values.
// No dependencies; used by tick_phase_lock_calibrator and tplc_checker.
package tplc_pkg;

   // Field and port widths
   localparam int DevW      = 32;
   localparam int ScaleW    = 20;
   localparam int NptW      = 30;
   localparam int HzW       = 9;
   localparam int RateW     = 10;
   localparam int NsW       = 62;
   localparam int ReqDataW  = 40;
   localparam int RspDataW  = 104;
   localparam int CsrIdxW   = 3;
   localparam int CsrDataW  = 16;
   localparam int StepCntW  = 5;

   // Result item bit layout
   localparam int RspSettledBit   = 0;
   localparam int RspLockedBit    = 1;
   localparam int RspBiasValidBit = 2;
   localparam int RspAdjLsb       = 3;
   localparam int RspNsLsb        = RspAdjLsb + DevW;

   // Last step indices of the serial units
   localparam logic [StepCntW-1:0] DivLastStep = 5'd31;
   localparam logic [StepCntW-1:0] MulLastStep = 5'd29;

   // Constants of the timing math
   localparam logic [NptW-1:0]   NsPerSecond = 30'd1000000000;
   localparam logic [RateW-1:0]  DefaultHz   = 10'd60;
   localparam logic [RateW-1:0]  MaxHz       = 10'd480;
   localparam logic [ScaleW-1:0] ScaleBase   = 20'd2;

   // Register reset values
   localparam logic [15:0]      BroadLowReset  = 16'd120;
   localparam logic [15:0]      BroadHighReset = 16'd65535;
   localparam logic [15:0]      FineMaxReset   = 16'd60;
   localparam logic [7:0]       AlphaNumReset  = 8'd1;
   localparam logic [7:0]       AlphaDenReset  = 8'd2;
   localparam logic [RateW-1:0] TickRateReset  = 10'd60;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_BROAD_LOW  = 3'd0,
      CSR_BROAD_HIGH = 3'd1,
      CSR_FINE_MAX   = 3'd2,
      CSR_ALPHA_NUM  = 3'd3,
      CSR_ALPHA_DEN  = 3'd4,
      CSR_TICK_RATE  = 3'd5
   } csr_index_type;

   typedef enum logic {
      CMD_RELEASE = 1'b0,
      CMD_FEED    = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_DONE
   } state_type;

endpackage

@@ src/tick_phase_lock_calibrator.sv @@
// Tick phase lock calibrator: bit-serial dividers and shift-add multiplier.
// Depends on tplc_pkg.
//
// An item that issues an adjustment passes from acceptance through
// classification of the deviation, two bit-serial restoring dividers
// (adjustment magnitude by gain denominator, scale or one, and one second
// in ns by the tick rate, side by side), the shift-add multiplier forming
// bias_ns, and a handoff that waits on a stalled output register. Release
// commands, feeds while locked or authority, zero deviations and feeds with
// the phase gate closed skip dividers and multiplier. One item is in work
// at a time; the next is accepted while a finished result waits in the
// output register. Configuration writes are taken every cycle.
module tick_phase_lock_calibrator #(
   parameter int SCALE_LIMIT = 1000000
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: authority_claim[0], phase_allows[1], deviation[33:2], zero pad
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tplc_pkg::ReqDataW-1:0]   req_tdata,
   // req_tuser: cmd[0]
   input  logic [0:0]                      req_tuser,
   // rsp_tdata: settled[0], locked[1], bias_valid[2], adjust_ticks[34:3],
   //            bias_ns[96:35], zero pad
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tplc_pkg::RspDataW-1:0]   rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tplc_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [tplc_pkg::CsrDataW-1:0]   csr_data
);
   import tplc_pkg::*;

   localparam logic [ScaleW-1:0] ScaleLimit = ScaleW'(SCALE_LIMIT);

   // Configuration registers
   logic [15:0]      broad_low_ff;
   logic [15:0]      broad_high_ff;
   logic [15:0]      fine_max_ff;
   logic [7:0]       alpha_num_ff;
   logic [7:0]       alpha_den_ff;
   logic [RateW-1:0] tick_rate_ff;

   // Lock state
   logic              authority_ff, authority_in;
   logic              locked_flag_ff, locked_flag_in;
   logic [ScaleW-1:0] scale_ff, scale_in;
   logic [1:0]        streak_ff, streak_in;

   // Sequencer
   state_type         state_ff, state_in;
   logic [StepCntW-1:0] cnt_ff;
   logic              item_load;
   logic              div_run;
   logic              div_last;
   logic              mul_run;
   logic              out_load;

   // Serial datapath
   logic [DevW-1:0]   quo_ff;
   logic [ScaleW-1:0] rem_ff;
   logic [ScaleW-1:0] div_ff;
   logic [DevW-1:0]   nquo_ff;
   logic [HzW-1:0]    nrem_ff;
   logic [NsW-1:0]    prod_ff;
   logic              neg_ff;
   logic              settled_ff;
   logic              locked_out_ff;

   // Output register
   logic              out_valid_ff;
   logic              out_settled_ff;
   logic              out_locked_ff;
   logic              out_bias_valid_ff;
   logic [DevW-1:0]   out_adj_ff;
   logic [NsW-1:0]    out_ns_ff;

   // Item decode
   logic              cmd_feed;
   logic              auth_in;
   logic              gate;
   logic [DevW-1:0]   dev;
   logic              dev_neg;
   logic [DevW-1:0]   mag;
   logic              in_broad;
   logic              in_fine;
   logic              in_over;
   logic [23:0]       fine_prod;
   logic              start_calc;
   logic              settled_in;
   logic [DevW-1:0]   dividend_in;
   logic [ScaleW-1:0] divisor_in;
   logic [1:0]        streak_inc;
   logic [7:0]        den_eff;
   logic [HzW-1:0]    hz_eff;

   // Divider and multiplier step logic
   logic [ScaleW:0]   shl;
   logic [ScaleW-1:0] diff;
   logic              ge;
   logic [ScaleW-1:0] rem_step;
   logic [DevW-1:0]   quo_step;
   logic [HzW:0]      nshl;
   logic [HzW-1:0]    ndiff;
   logic              nge;
   logic [HzW-1:0]    nrem_step;
   logic [DevW-1:0]   nquo_step;
   logic [DevW:0]     madd;

   assign csr_ready = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         broad_low_ff  <= BroadLowReset;
         broad_high_ff <= BroadHighReset;
         fine_max_ff   <= FineMaxReset;
         alpha_num_ff  <= AlphaNumReset;
         alpha_den_ff  <= AlphaDenReset;
         tick_rate_ff  <= TickRateReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BROAD_LOW:  broad_low_ff  <= csr_data;
            CSR_BROAD_HIGH: broad_high_ff <= csr_data;
            CSR_FINE_MAX:   fine_max_ff   <= csr_data;
            CSR_ALPHA_NUM:  alpha_num_ff  <= csr_data[7:0];
            CSR_ALPHA_DEN:  alpha_den_ff  <= csr_data[7:0];
            CSR_TICK_RATE:  tick_rate_ff  <= csr_data[RateW-1:0];
            default: ;
         endcase
      end
   end

   // Effective gain denominator and clamped tick rate
   assign den_eff = (alpha_den_ff == 8'd0) ? 8'd1 : alpha_den_ff;
   always_comb begin
      if (tick_rate_ff == '0) begin
         hz_eff = DefaultHz[HzW-1:0];
      end else if (tick_rate_ff > MaxHz) begin
         hz_eff = MaxHz[HzW-1:0];
      end else begin
         hz_eff = tick_rate_ff[HzW-1:0];
      end
   end

   // Item fields and band compares
   assign cmd_feed  = (cmd_type'(req_tuser[0]) == CMD_FEED);
   assign auth_in   = req_tdata[0];
   assign gate      = req_tdata[1];
   assign dev       = req_tdata[DevW+1:2];
   assign dev_neg   = dev[DevW-1];
   assign mag       = dev_neg ? (~dev + 32'd1) : dev;
   assign in_broad  = (mag >= 32'(broad_low_ff)) && (mag <= 32'(broad_high_ff));
   assign in_fine   = (mag <= 32'(fine_max_ff));
   assign in_over   = (mag > 32'(broad_high_ff));
   assign fine_prod = 24'(mag[15:0]) * 24'(alpha_num_ff);
   assign streak_inc = streak_ff + 2'd1;

   // Command decode: state updates and divider operands
   always_comb begin
      authority_in   = authority_ff;
      locked_flag_in = locked_flag_ff;
      scale_in       = scale_ff;
      streak_in      = streak_ff;
      settled_in     = 1'b0;
      start_calc     = 1'b0;
      dividend_in    = mag;
      divisor_in     = 20'd1;
      if (!cmd_feed) begin
         authority_in   = auth_in;
         locked_flag_in = auth_in;
         scale_in       = ScaleBase;
         streak_in      = 2'd0;
      end else begin
         priority if (authority_ff || locked_flag_ff) begin
            settled_in = 1'b1;
         end else if (dev == '0) begin
            locked_flag_in = 1'b1;
            settled_in     = 1'b1;
         end else if (gate) begin
            start_calc = 1'b1;
            priority if (in_broad) begin
               streak_in = 2'd0;
            end else if (in_fine) begin
               dividend_in = 32'(fine_prod);
               divisor_in  = 20'(den_eff);
               streak_in   = 2'd0;
            end else if (in_over) begin
               divisor_in = (scale_ff < ScaleBase) ? ScaleBase : scale_ff;
               scale_in   = ScaleBase;
            end else begin
               // undershoot: second in a row bumps the scale
               if (streak_inc[1]) begin
                  if (scale_ff < ScaleLimit) begin
                     scale_in = scale_ff + 20'd1;
                  end
                  streak_in = 2'd0;
               end else begin
                  streak_in = streak_inc;
               end
            end
         end else begin
            settled_in = 1'b0;
         end
      end
   end

   // Restoring divider steps, one quotient bit each
   assign shl       = {rem_ff, quo_ff[DevW-1]};
   assign diff      = shl[ScaleW-1:0] - div_ff;
   assign ge        = (shl >= {1'b0, div_ff});
   assign rem_step  = ge ? diff : shl[ScaleW-1:0];
   assign quo_step  = {quo_ff[DevW-2:0], ge};
   assign nshl      = {nrem_ff, nquo_ff[DevW-1]};
   assign ndiff     = nshl[HzW-1:0] - hz_eff;
   assign nge       = (nshl >= {1'b0, hz_eff});
   assign nrem_step = nge ? ndiff : nshl[HzW-1:0];
   assign nquo_step = {nquo_ff[DevW-2:0], nge};

   // Shift-add multiplier step: adjustment magnitude times ns per tick
   assign madd = {1'b0, prod_ff[NsW-1:NptW]} + (prod_ff[0] ? {1'b0, quo_ff} : 33'd0);

   // Sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer next state and controls
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      item_load  = 1'b0;
      div_run    = 1'b0;
      div_last   = 1'b0;
      mul_run    = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               item_load = 1'b1;
               state_in  = start_calc ? ST_DIV : ST_DONE;
            end
         end
         ST_DIV: begin
            div_run = 1'b1;
            if (cnt_ff == DivLastStep) begin
               div_last = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mul_run = 1'b1;
            if (cnt_ff == MulLastStep) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Lock state and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         authority_ff   <= 1'b0;
         locked_flag_ff <= 1'b0;
         scale_ff       <= '0;
         streak_ff      <= 2'd0;
         cnt_ff         <= '0;
      end else begin
         if (item_load) begin
            authority_ff   <= authority_in;
            locked_flag_ff <= locked_flag_in;
            scale_ff       <= scale_in;
            streak_ff      <= streak_in;
         end
         if (item_load || div_last) begin
            cnt_ff <= '0;
         end else if (div_run || mul_run) begin
            cnt_ff <= cnt_ff + 5'd1;
         end
      end
   end

   // Serial datapath
   always_ff @(posedge clock) begin
      if (item_load) begin
         neg_ff        <= dev_neg;
         settled_ff    <= settled_in;
         locked_out_ff <= locked_flag_in;
         quo_ff        <= start_calc ? dividend_in : '0;
         rem_ff        <= '0;
         div_ff        <= divisor_in;
         nquo_ff       <= 32'(NsPerSecond);
         nrem_ff       <= '0;
         prod_ff       <= '0;
      end else if (div_run) begin
         quo_ff  <= quo_step;
         rem_ff  <= rem_step;
         nquo_ff <= nquo_step;
         nrem_ff <= nrem_step;
         if (div_last) begin
            prod_ff <= {32'd0, nquo_step[NptW-1:0]};
         end
      end else if (mul_run) begin
         prod_ff <= {madd, prod_ff[NptW-1:1]};
      end
   end

   // Output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output register payload, sign applied to magnitudes
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_settled_ff    <= settled_ff;
         out_locked_ff     <= locked_out_ff;
         out_bias_valid_ff <= (quo_ff != '0);
         out_adj_ff        <= neg_ff ? (~quo_ff + 32'd1) : quo_ff;
         out_ns_ff         <= neg_ff ? (~prod_ff + 62'd1) : prod_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_ns_ff, out_adj_ff, out_bias_valid_ff,
                        out_locked_ff, out_settled_ff};

endmodule

@@ src/tplc_checker.sv @@
// Port-level checker for the tick phase lock calibrator, bound to the top.
// Depends on tplc_pkg and tick_phase_lock_calibrator_assert.svh.
`include "tick_phase_lock_calibrator_assert.svh"

module tplc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tplc_pkg::RspDataW-1:0]   rsp_tdata
);
   import tplc_pkg::*;

   logic            settled;
   logic            bias_valid;
   logic [DevW-1:0] adj;
   logic [NsW-1:0]  bias_ns;

   assign settled    = rsp_tdata[RspSettledBit];
   assign bias_valid = rsp_tdata[RspBiasValidBit];
   assign adj        = rsp_tdata[RspAdjLsb +: DevW];
   assign bias_ns    = rsp_tdata[RspNsLsb +: NsW];

   // A stalled result holds
   `TPLC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "tplc: stalled result changed")

   // One item in work: input closes right after an accepted item
   `TPLC_ASSERT_NEXT(a_one_in_work, clock, reset, req_tvalid && req_tready, !req_tready, "tplc: input open while an item is in work")

   // bias_valid marks exactly the nonzero adjustments
   `TPLC_ASSERT_SAME(a_bias_flag, clock, reset, rsp_tvalid, bias_valid == (adj != '0), "tplc: bias_valid disagrees with adjust_ticks")

   // No adjustment means no ns bias either
   `TPLC_ASSERT_SAME(a_no_bias, clock, reset, rsp_tvalid && !bias_valid, bias_ns == '0, "tplc: bias_ns without adjustment")

   // A settled feed never carries an adjustment
   `TPLC_ASSERT_SAME(a_settled_quiet, clock, reset, rsp_tvalid && settled, !bias_valid, "tplc: settled result carries adjustment")

endmodule

bind tick_phase_lock_calibrator tplc_checker u_tplc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
